>>> design/clcsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clcsf_pkg;

  // Number of stroke points the block can hold.
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Q24.24 constants.
  localparam logic signed [47:0] ONE  = 48'sd16777216;
  localparam logic signed [47:0] HALF = 48'sd8388608;
  localparam logic signed [47:0] TWO  = 48'sd33554432;
  localparam logic [46:0]        MAG_MAX = 47'h7FFF_FFFF_FFFF;

  localparam logic signed [51:0] SAT_HI = 52'sd140737488355327;
  localparam logic signed [51:0] SAT_LO = -52'sd140737488355328;

  // Input word kinds.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_FIN = 2'd2
  } op_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Clamp a widened sum to the 48-bit signed range.
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[47:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/clcsf_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative fixed-point unit: Q24.24 multiply, Q24.24 divide and integer
// square root, one bit (or one root digit) per cycle.
module clcsf_alu (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  clcsf_pkg::alu_req_t    req_i,
  input  wire logic signed [47:0] a_i,
  input  wire logic signed [47:0] b_i,
  input  wire logic [48:0]       sq_i,
  output logic                   done_o,
  output logic signed [47:0]     res_o
);

  localparam logic [6:0] MUL_STEPS  = 7'd48;
  localparam logic [6:0] DIV_STEPS  = 7'd72;
  localparam logic [6:0] SQRT_STEPS = 7'd41;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [6:0]        cnt_q, cnt_d;
  clcsf_pkg::alu_op_e op_q, op_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic              ovf_q, ovf_d;
  logic [95:0]       acc_q, acc_d;
  logic [47:0]       ma_q, ma_d;
  logic [47:0]       mb_q, mb_d;
  logic [81:0]       num_q, num_d;
  logic [47:0]       rem_q, rem_d;
  logic [46:0]       quo_q, quo_d;
  logic signed [47:0] res_q, res_d;

  logic [47:0] mag_a, mag_b;
  logic [48:0] dr2;
  logic [44:0] sr2, strial;
  logic [46:0] mres;

  assign mag_a = a_i[47] ? 48'(-a_i) : 48'(a_i);
  assign mag_b = b_i[47] ? 48'(-b_i) : 48'(b_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    ovf_d  = ovf_q;
    acc_d  = acc_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    res_d  = res_q;
    dr2    = {rem_q, num_q[81]};
    sr2    = {rem_q[42:0], num_q[81:80]};
    strial = {2'b00, quo_q[40:0], 2'b01};
    mres   = (|acc_q[95:71]) ? clcsf_pkg::MAG_MAX : acc_q[70:24];

    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        neg_d  = a_i[47] ^ b_i[47];
        zero_d = (mag_b == 48'd0);
        ovf_d  = 1'b0;
        acc_d  = '0;
        rem_d  = '0;
        quo_d  = '0;
        ma_d   = mag_b;
        mb_d   = mag_b;
        num_d  = '0;
        cnt_d  = MUL_STEPS;
        unique case (req_i.op)
          clcsf_pkg::ALU_MUL: begin
            ma_d  = mag_a;
            cnt_d = MUL_STEPS;
          end
          clcsf_pkg::ALU_DIV: begin
            num_d = {mag_a, 24'd0, 10'd0};
            cnt_d = DIV_STEPS;
          end
          clcsf_pkg::ALU_SQRT: begin
            num_d = {1'b0, sq_i, 32'd0};
            cnt_d = SQRT_STEPS;
          end
          default: begin
            busy_d = 1'b0;
          end
        endcase
      end
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      unique case (op_q)
        clcsf_pkg::ALU_MUL: begin
          acc_d = {acc_q[94:0], 1'b0} + (mb_q[47] ? {48'd0, ma_q} : 96'd0);
          mb_d  = {mb_q[46:0], 1'b0};
        end
        clcsf_pkg::ALU_DIV: begin
          ovf_d = ovf_q | quo_q[46];
          if (dr2 >= {1'b0, ma_q}) begin
            dr2   = dr2 - {1'b0, ma_q};
            quo_d = {quo_q[45:0], 1'b1};
          end else begin
            quo_d = {quo_q[45:0], 1'b0};
          end
          rem_d = dr2[47:0];
          num_d = {num_q[80:0], 1'b0};
        end
        clcsf_pkg::ALU_SQRT: begin
          if (sr2 >= strial) begin
            sr2   = sr2 - strial;
            quo_d = {quo_q[45:0], 1'b1};
          end else begin
            quo_d = {quo_q[45:0], 1'b0};
          end
          rem_d = 48'(sr2);
          num_d = {num_q[79:0], 2'b00};
        end
        default: begin
          cnt_d = 7'd0;
        end
      endcase
    end else begin
      busy_d = 1'b0;
      done_d = 1'b1;
      unique case (op_q)
        clcsf_pkg::ALU_MUL: begin
          res_d = neg_q ? -$signed({1'b0, mres}) : $signed({1'b0, mres});
        end
        clcsf_pkg::ALU_DIV: begin
          if (zero_q) begin
            res_d = '0;
          end else if (ovf_q) begin
            res_d = neg_q ? -$signed({1'b0, clcsf_pkg::MAG_MAX})
                          : $signed({1'b0, clcsf_pkg::MAG_MAX});
          end else begin
            res_d = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
          end
        end
        clcsf_pkg::ALU_SQRT: begin
          res_d = $signed({7'd0, quo_q[40:0]});
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= clcsf_pkg::ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    ovf_q  <= ovf_d;
    acc_q  <= acc_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> design/chord_length_cubic_spline_fitter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: point_x, point_y, pen_down
//                                               tuser: op
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: one cubic segment, tlast: last
//
// An add word is stored straight from the input; a delete word that removes a point
// passes through S_RELOAD and S_RELOAD2, which fetch the new last point. The run time
// of a finish word is set by the shared iterative unit that does its arithmetic,
// and a segment alone needs sixteen quotients. Input is not taken while a finish runs.
// The segment output sits in its own register, so a stalled sink only holds the
// sequencer at the hand-over of the next segment. Reset clears the point count, the
// sequencer and the output valid; the stores themselves are not cleared.
module chord_length_cubic_spline_fitter_core #(
  parameter int unsigned MAX_POINTS = clcsf_pkg::MAX_POINTS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_axis_tvalid,
  output logic          s_axis_tready,
  // point_x [23:0], point_y [47:24], pen_down [48], zero fill [55:49]
  input  wire  [55:0]   s_axis_tdata,
  // op [1:0]
  input  wire  [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  wire           m_axis_tready,
  // start_x [47:0], start_y [95:48], slope_x [143:96], slope_y [191:144],
  // quad_x [239:192], quad_y [287:240], cubic_x [335:288], cubic_y [383:336],
  // seg_length [430:384], pressure_start [431], pressure_end [432], zero fill [439:433]
  output logic [439:0]  m_axis_tdata,
  // last
  output logic          m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [46:0] {
    S_IDLE    = 47'd1 << 0,
    S_RELOAD  = 47'd1 << 1,
    S_RELOAD2 = 47'd1 << 2,
    S_WAIT    = 47'd1 << 3,
    S_LEN_RD  = 47'd1 << 4,
    S_LEN_SQ  = 47'd1 << 5,
    S_LEN_SQ2 = 47'd1 << 6,
    S_LEN_RT  = 47'd1 << 7,
    S_LEN_WR  = 47'd1 << 8,
    S_CO_RD   = 47'd1 << 9,
    S_CO_LD   = 47'd1 << 10,
    S_CO_MUL  = 47'd1 << 11,
    S_CO_BP   = 47'd1 << 12,
    S_CO_DIV  = 47'd1 << 13,
    S_CO_WR   = 47'd1 << 14,
    S_FW0_RD  = 47'd1 << 15,
    S_FW0_LD  = 47'd1 << 16,
    S_FW0_DIV = 47'd1 << 17,
    S_FW0_WR  = 47'd1 << 18,
    S_FW_RD   = 47'd1 << 19,
    S_FW_LD   = 47'd1 << 20,
    S_FW_LD2  = 47'd1 << 21,
    S_FW_L    = 47'd1 << 22,
    S_FW_Q0   = 47'd1 << 23,
    S_FW_M0   = 47'd1 << 24,
    S_FW_Q1   = 47'd1 << 25,
    S_FW_M1   = 47'd1 << 26,
    S_FW_SUM  = 47'd1 << 27,
    S_FW_R    = 47'd1 << 28,
    S_FW_MUL  = 47'd1 << 29,
    S_FW_SUB  = 47'd1 << 30,
    S_FW_WR   = 47'd1 << 31,
    S_BK_RD   = 47'd1 << 32,
    S_BK_MUL  = 47'd1 << 33,
    S_BK_WR   = 47'd1 << 34,
    S_EM_RD   = 47'd1 << 35,
    S_EM_LD   = 47'd1 << 36,
    S_EM_A    = 47'd1 << 37,
    S_EM_B    = 47'd1 << 38,
    S_EM_C    = 47'd1 << 39,
    S_EM_D    = 47'd1 << 40,
    S_EM_E    = 47'd1 << 41,
    S_EM_F    = 47'd1 << 42,
    S_EM_G    = 47'd1 << 43,
    S_EM_H    = 47'd1 << 44,
    S_EM_I    = 47'd1 << 45,
    S_EM_PUSH = 47'd1 << 46
  } state_e;

  // Coordinate of a stored point on one axis, widened from Q16.8 to Q16.24 (sign-extended to Q24.24 where used).
  function automatic logic signed [39:0] coord(input logic [48:0] pt, input logic ax);
    logic [23:0] raw;
    raw = ax ? pt[47:24] : pt[23:0];
    return $signed({raw, 16'd0});
  endfunction

  // Stores.
  logic [48:0] point_mem [MAX_POINTS];
  logic [47:0] len_mem   [MAX_POINTS];
  logic [47:0] diag_mem  [MAX_POINTS];
  logic [47:0] up_mem    [MAX_POINTS];
  logic [47:0] wx_mem    [MAX_POINTS];
  logic [47:0] wy_mem    [MAX_POINTS];

  logic          pt_we, len_we, dg_we, up_we, w_we;
  logic [AW-1:0] pt_wa, len_wa, dg_wa, up_wa, w_wa;
  logic [48:0]   pt_wd;
  logic [47:0]   len_wd, dg_wd, up_wd, w_wd;
  logic [AW-1:0] pt_ra_a, pt_ra_b, len_ra_a, len_ra_b, dg_ra, up_ra, w_ra_a, w_ra_b;
  logic [48:0]   pt_rd_a, pt_rd_b;
  logic [47:0]   len_rd_a, len_rd_b, dg_rd, up_rd;
  logic [47:0]   wx_rd_a, wx_rd_b, wy_rd_a, wy_rd_b;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      point_mem[pt_wa] <= pt_wd;
    end
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (dg_we) begin
      diag_mem[dg_wa] <= dg_wd;
    end
    if (up_we) begin
      up_mem[up_wa] <= up_wd;
    end
    if (w_we && !ax_q) begin
      wx_mem[w_wa] <= w_wd;
    end
    if (w_we && ax_q) begin
      wy_mem[w_wa] <= w_wd;
    end
    pt_rd_a  <= point_mem[pt_ra_a];
    pt_rd_b  <= point_mem[pt_ra_b];
    len_rd_a <= len_mem[len_ra_a];
    len_rd_b <= len_mem[len_ra_b];
    dg_rd    <= diag_mem[dg_ra];
    up_rd    <= up_mem[up_ra];
    wx_rd_a  <= wx_mem[w_ra_a];
    wx_rd_b  <= wx_mem[w_ra_b];
    wy_rd_a  <= wy_mem[w_ra_a];
    wy_rd_b  <= wy_mem[w_ra_b];
  end

  // Control registers.
  state_e        state_q, state_d;
  state_e        ret_q, ret_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d;
  logic          ax_q, ax_d;
  logic          m_valid_q, m_valid_d;

  // Datapath registers.
  logic [47:0]        last_q, last_d;
  logic [48:0]        sq_q, sq_d;
  logic signed [24:0] dy_q, dy_d;
  logic signed [47:0] res_q, res_d;
  logic signed [47:0] h0_q, h0_d, h1_q, h1_d, dg_q, dg_d;
  logic signed [47:0] prev_q, prev_d, t0_q, t0_d, wa_q, wa_d;
  logic signed [39:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic [48:0]        pt0_q, pt0_d, pt1_q, pt1_d;
  logic signed [47:0] wx0_q, wx0_d, wx1_q, wx1_d, wy0_q, wy0_d, wy1_q, wy1_d;
  logic signed [47:0] qx_q, qx_d, qy_q, qy_d, kx_q, kx_d, ky_q, ky_d;
  logic [439:0]       m_data_q, m_data_d;
  logic               m_last_q, m_last_d;

  // Shared arithmetic unit.
  clcsf_pkg::alu_req_t alu_req;
  logic signed [47:0]  alu_a, alu_b, alu_res;
  logic                alu_done;

  clcsf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sq_i   (sq_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Helpers.
  logic [AW-1:0]      idx, idx_m1, idx_p1;
  logic               at_last, seg_last, in_acc;
  logic [47:0]        in_xy;
  logic signed [24:0] dx_w, dy_w;
  logic signed [49:0] dx2, dy2;
  logic signed [47:0] lower, emd, ewa, ewb, bp, fw_d3, fw_d1, fw_d0;
  clcsf_pkg::op_e     in_op;

  assign idx      = i_q[AW-1:0];
  assign idx_m1   = idx - AW'(1);
  assign idx_p1   = idx + AW'(1);
  assign at_last  = (CW'(i_q + CW'(1)) == n_q);
  assign seg_last = (CW'(i_q + CW'(2)) == n_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_xy    = s_axis_tdata[47:0];
  assign in_op    = clcsf_pkg::op_e'(s_axis_tuser);

  assign dx_w = $signed({pt_rd_b[23], pt_rd_b[23:0]}) - $signed({pt_rd_a[23], pt_rd_a[23:0]});
  assign dy_w = $signed({pt_rd_b[47], pt_rd_b[47:24]})
              - $signed({pt_rd_a[47], pt_rd_a[47:24]});
  assign dx2  = dx_w * dx_w;
  assign dy2  = dy_q * dy_q;

  // The last row of the system uses a unit lower coefficient.
  assign lower = at_last ? clcsf_pkg::ONE : h1_q;
  assign bp    = clcsf_pkg::sat48((at_last ? 52'(clcsf_pkg::TWO)
                                   : 52'(clcsf_pkg::sat48(52'(h0_q) + 52'(h0_q)
                                                          + 52'(h1_q) + 52'(h1_q))))
                                  - 52'(res_q));
  assign fw_d1 = 48'(c1_q) - 48'(c0_q);
  assign fw_d0 = 48'(c2_q) - 48'(c1_q);
  assign fw_d3 = fw_d1 + fw_d1 + fw_d1;

  // Segment values for the axis being worked on.
  assign emd = 48'(coord(pt1_q, ax_q)) - 48'(coord(pt0_q, ax_q));
  assign ewa = ax_q ? wy0_q : wx0_q;
  assign ewb = ax_q ? wy1_q : wx1_q;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    n_d       = n_q;
    i_d       = i_q;
    ax_d      = ax_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    last_d    = last_q;
    sq_d      = sq_q;
    dy_d      = dy_q;
    res_d     = res_q;
    h0_d      = h0_q;
    h1_d      = h1_q;
    dg_d      = dg_q;
    prev_d    = prev_q;
    t0_d      = t0_q;
    wa_d      = wa_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    c2_d      = c2_q;
    pt0_d     = pt0_q;
    pt1_d     = pt1_q;
    wx0_d     = wx0_q;
    wx1_d     = wx1_q;
    wy0_d     = wy0_q;
    wy1_d     = wy1_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    kx_d      = kx_q;
    ky_d      = ky_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    alu_req.start = 1'b0;
    alu_req.op    = clcsf_pkg::ALU_DIV;
    alu_a         = '0;
    alu_b         = '0;

    pt_we  = 1'b0;
    pt_wa  = n_q[AW-1:0];
    pt_wd  = {s_axis_tdata[48], in_xy};
    len_we = 1'b0;
    len_wa = idx;
    len_wd = res_q;
    dg_we  = 1'b0;
    dg_wa  = idx;
    dg_wd  = bp;
    up_we  = 1'b0;
    up_wa  = idx;
    up_wd  = res_q;
    w_we   = 1'b0;
    w_wa   = idx;
    w_wd   = res_q;

    pt_ra_a  = idx;
    pt_ra_b  = idx_p1;
    len_ra_a = idx;
    len_ra_b = idx_p1;
    dg_ra    = idx;
    up_ra    = idx;
    w_ra_a   = idx;
    w_ra_b   = idx_p1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            clcsf_pkg::OP_ADD: begin
              // Drop the word when the store is full or the point repeats.
              if (n_q != CW'(MAX_POINTS) && !(n_q != '0 && last_q == in_xy)) begin
                pt_we  = 1'b1;
                n_d    = n_q + CW'(1);
                last_d = in_xy;
              end
            end
            clcsf_pkg::OP_DEL: begin
              if (n_q > CW'(1)) begin
                n_d     = n_q - CW'(1);
                state_d = S_RELOAD;
              end
            end
            clcsf_pkg::OP_FIN: begin
              if (n_q > CW'(1)) begin
                i_d     = '0;
                state_d = S_LEN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // After a delete the new last point is fetched for the repeat check.
      S_RELOAD: begin
        pt_ra_a = AW'(n_q - CW'(1));
        state_d = S_RELOAD2;
      end
      S_RELOAD2: begin
        last_d  = pt_rd_a[47:0];
        state_d = S_IDLE;
      end
      S_WAIT: begin
        if (alu_done) begin
          res_d   = alu_res;
          state_d = ret_q;
        end
      end

      // Chord lengths.
      S_LEN_RD: begin
        state_d = S_LEN_SQ;
      end
      S_LEN_SQ: begin
        sq_d    = dx2[48:0];
        dy_d    = dy_w;
        state_d = S_LEN_SQ2;
      end
      S_LEN_SQ2: begin
        sq_d    = sq_q + dy2[48:0];
        state_d = S_LEN_RT;
      end
      S_LEN_RT: begin
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_SQRT;
        ret_d         = S_LEN_WR;
        state_d       = S_WAIT;
      end
      S_LEN_WR: begin
        len_we = 1'b1;
        if (seg_last) begin
          dg_we   = 1'b1;
          dg_wa   = '0;
          dg_wd   = clcsf_pkg::ONE;
          up_we   = 1'b1;
          up_wa   = '0;
          up_wd   = clcsf_pkg::HALF;
          prev_d  = clcsf_pkg::HALF;
          i_d     = CW'(1);
          state_d = S_CO_RD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_LEN_RD;
        end
      end

      // Forward elimination of the matrix coefficients.
      S_CO_RD: begin
        len_ra_a = idx_m1;
        len_ra_b = idx;
        state_d  = S_CO_LD;
      end
      S_CO_LD: begin
        h0_d    = len_rd_a;
        h1_d    = len_rd_b;
        state_d = S_CO_MUL;
      end
      S_CO_MUL: begin
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_MUL;
        alu_a         = lower;
        alu_b         = prev_q;
        ret_d         = S_CO_BP;
        state_d       = S_WAIT;
      end
      S_CO_BP: begin
        dg_we   = 1'b1;
        dg_d    = bp;
        state_d = S_CO_DIV;
      end
      S_CO_DIV: begin
        alu_req.start = 1'b1;
        alu_a         = at_last ? '0 : h0_q;
        alu_b         = dg_q;
        ret_d         = S_CO_WR;
        state_d       = S_WAIT;
      end
      S_CO_WR: begin
        up_we  = 1'b1;
        prev_d = res_q;
        if (at_last) begin
          ax_d    = 1'b0;
          state_d = S_FW0_RD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_CO_RD;
        end
      end

      // Right-hand side elimination, first row.
      S_FW0_RD: begin
        pt_ra_a  = '0;
        pt_ra_b  = AW'(1);
        len_ra_a = '0;
        state_d  = S_FW0_LD;
      end
      S_FW0_LD: begin
        c0_d    = coord(pt_rd_a, ax_q);
        c1_d    = coord(pt_rd_b, ax_q);
        h0_d    = len_rd_a;
        state_d = S_FW0_DIV;
      end
      S_FW0_DIV: begin
        alu_req.start = 1'b1;
        alu_a         = fw_d3;
        alu_b         = h0_q + h0_q;
        ret_d         = S_FW0_WR;
        state_d       = S_WAIT;
      end
      S_FW0_WR: begin
        w_we    = 1'b1;
        w_wa    = '0;
        prev_d  = res_q;
        i_d     = CW'(1);
        state_d = S_FW_RD;
      end

      // Right-hand side elimination, remaining rows.
      S_FW_RD: begin
        pt_ra_a  = idx_m1;
        pt_ra_b  = idx;
        len_ra_a = idx_m1;
        len_ra_b = idx;
        state_d  = S_FW_LD;
      end
      S_FW_LD: begin
        c0_d    = coord(pt_rd_a, ax_q);
        c1_d    = coord(pt_rd_b, ax_q);
        h0_d    = len_rd_a;
        h1_d    = len_rd_b;
        dg_d    = dg_rd;
        pt_ra_a = idx_p1;
        state_d = S_FW_LD2;
      end
      S_FW_LD2: begin
        c2_d    = coord(pt_rd_a, ax_q);
        state_d = at_last ? S_FW_L : S_FW_Q0;
      end
      S_FW_L: begin
        alu_req.start = 1'b1;
        alu_a         = fw_d3;
        alu_b         = h0_q;
        ret_d         = S_FW_R;
        state_d       = S_WAIT;
      end
      S_FW_Q0: begin
        alu_req.start = 1'b1;
        alu_a         = h0_q;
        alu_b         = h1_q;
        ret_d         = S_FW_M0;
        state_d       = S_WAIT;
      end
      S_FW_M0: begin
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_MUL;
        alu_a         = res_q;
        alu_b         = fw_d0;
        ret_d         = S_FW_Q1;
        state_d       = S_WAIT;
      end
      S_FW_Q1: begin
        t0_d          = res_q;
        alu_req.start = 1'b1;
        alu_a         = h1_q;
        alu_b         = h0_q;
        ret_d         = S_FW_M1;
        state_d       = S_WAIT;
      end
      S_FW_M1: begin
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_MUL;
        alu_a         = res_q;
        alu_b         = fw_d1;
        ret_d         = S_FW_SUM;
        state_d       = S_WAIT;
      end
      S_FW_SUM: begin
        t0_d = clcsf_pkg::sat48(52'(clcsf_pkg::sat48(52'(t0_q) + 52'(res_q))) * 52'sd3);
        state_d = S_FW_MUL;
      end
      S_FW_R: begin
        t0_d    = res_q;
        state_d = S_FW_MUL;
      end
      S_FW_MUL: begin
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_MUL;
        alu_a         = lower;
        alu_b         = prev_q;
        ret_d         = S_FW_SUB;
        state_d       = S_WAIT;
      end
      S_FW_SUB: begin
        alu_req.start = 1'b1;
        alu_a         = clcsf_pkg::sat48(52'(t0_q) - 52'(res_q));
        alu_b         = dg_q;
        ret_d         = S_FW_WR;
        state_d       = S_WAIT;
      end
      S_FW_WR: begin
        w_we   = 1'b1;
        prev_d = res_q;
        if (at_last) begin
          i_d     = CW'(n_q - CW'(2));
          state_d = S_BK_RD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_FW_RD;
        end
      end

      // Back substitution; prev holds the slope of the row below.
      S_BK_RD: begin
        state_d = S_BK_MUL;
      end
      S_BK_MUL: begin
        wa_d          = ax_q ? wy_rd_a : wx_rd_a;
        alu_req.start = 1'b1;
        alu_req.op    = clcsf_pkg::ALU_MUL;
        alu_a         = up_rd;
        alu_b         = prev_q;
        ret_d         = S_BK_WR;
        state_d       = S_WAIT;
      end
      S_BK_WR: begin
        w_we   = 1'b1;
        w_wd   = clcsf_pkg::sat48(52'(wa_q) - 52'(res_q));
        prev_d = w_wd;
        if (i_q == '0) begin
          if (!ax_q) begin
            ax_d    = 1'b1;
            state_d = S_FW0_RD;
          end else begin
            ax_d    = 1'b0;
            state_d = S_EM_RD;
          end
        end else begin
          i_d     = i_q - CW'(1);
          state_d = S_BK_RD;
        end
      end

      // Segment coefficients, x axis then y axis.
      S_EM_RD: begin
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        pt0_d   = pt_rd_a;
        pt1_d   = pt_rd_b;
        h0_d    = len_rd_a;
        wx0_d   = wx_rd_a;
        wx1_d   = wx_rd_b;
        wy0_d   = wy_rd_a;
        wy1_d   = wy_rd_b;
        ax_d    = 1'b0;
        state_d = S_EM_A;
      end
      S_EM_A: begin
        alu_req.start = 1'b1;
        alu_a         = emd + emd + emd;
        alu_b         = h0_q;
        ret_d         = S_EM_B;
        state_d       = S_WAIT;
      end
      S_EM_B: begin
        alu_req.start = 1'b1;
        alu_a         = res_q;
        alu_b         = h0_q;
        ret_d         = S_EM_C;
        state_d       = S_WAIT;
      end
      S_EM_C: begin
        t0_d          = res_q;
        alu_req.start = 1'b1;
        alu_a         = clcsf_pkg::sat48(52'(ewb) + 52'(ewa) + 52'(ewa));
        alu_b         = h0_q;
        ret_d         = S_EM_D;
        state_d       = S_WAIT;
      end
      S_EM_D: begin
        if (ax_q) begin
          qy_d = clcsf_pkg::sat48(52'(t0_q) - 52'(res_q));
        end else begin
          qx_d = clcsf_pkg::sat48(52'(t0_q) - 52'(res_q));
        end
        alu_req.start = 1'b1;
        alu_a         = -(emd + emd);
        alu_b         = h0_q;
        ret_d         = S_EM_E;
        state_d       = S_WAIT;
      end
      S_EM_E: begin
        alu_req.start = 1'b1;
        alu_a         = res_q;
        alu_b         = h0_q;
        ret_d         = S_EM_F;
        state_d       = S_WAIT;
      end
      S_EM_F: begin
        alu_req.start = 1'b1;
        alu_a         = res_q;
        alu_b         = h0_q;
        ret_d         = S_EM_G;
        state_d       = S_WAIT;
      end
      S_EM_G: begin
        t0_d          = res_q;
        alu_req.start = 1'b1;
        alu_a         = clcsf_pkg::sat48(52'(ewb) + 52'(ewa));
        alu_b         = h0_q;
        ret_d         = S_EM_H;
        state_d       = S_WAIT;
      end
      S_EM_H: begin
        alu_req.start = 1'b1;
        alu_a         = res_q;
        alu_b         = h0_q;
        ret_d         = S_EM_I;
        state_d       = S_WAIT;
      end
      S_EM_I: begin
        if (ax_q) begin
          ky_d    = clcsf_pkg::sat48(52'(t0_q) + 52'(res_q));
          state_d = S_EM_PUSH;
        end else begin
          kx_d    = clcsf_pkg::sat48(52'(t0_q) + 52'(res_q));
          ax_d    = 1'b1;
          state_d = S_EM_A;
        end
      end
      // Hand the segment to the output register once it is free.
      S_EM_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_last_d  = seg_last;
          m_data_d  = {7'd0, pt1_q[48], pt0_q[48], h0_q[46:0],
                       ky_q, kx_q, qy_q, qx_q, wy0_q, wx0_q,
                       48'(coord(pt0_q, 1'b1)), 48'(coord(pt0_q, 1'b0))};
          ax_d      = 1'b0;
          if (seg_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      n_q       <= '0;
      i_q       <= '0;
      ax_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      n_q       <= n_d;
      i_q       <= i_d;
      ax_q      <= ax_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    sq_q     <= sq_d;
    dy_q     <= dy_d;
    res_q    <= res_d;
    h0_q     <= h0_d;
    h1_q     <= h1_d;
    dg_q     <= dg_d;
    prev_q   <= prev_d;
    t0_q     <= t0_d;
    wa_q     <= wa_d;
    c0_q     <= c0_d;
    c1_q     <= c1_d;
    c2_q     <= c2_d;
    pt0_q    <= pt0_d;
    pt1_q    <= pt1_d;
    wx0_q    <= wx0_d;
    wx1_q    <= wx1_d;
    wy0_q    <= wy0_d;
    wy1_q    <= wy1_d;
    qx_q     <= qx_d;
    qy_q     <= qy_d;
    kx_q     <= kx_d;
    ky_q     <= ky_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int            NPTS     = 64;
  localparam int            IDLE_MAX = 400000;
  localparam longint        QONE     = 64'sd16777216;
  localparam logic [127:0]  MAG47    = 128'h7FFF_FFFF_FFFF;
  localparam logic [1:0]    OP_SPARE = 2'd3;

  typedef struct {
    logic [439:0] d;
    logic         l;
  } seg_s;

  typedef struct {
    logic [1:0] op;
    longint     x;
    longint     y;
    bit         pen;
    int         typed;  // -1: use the spline predictor, else the number of typed segments
  } row_s;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [439:0] m_axis_tdata;
  wire          m_axis_tlast;

  chord_length_cubic_spline_fitter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Stroke held by the predictor, raw Q16.8 coordinates.
  longint px [NPTS];
  longint py [NPTS];
  bit     pp [NPTS];
  int     np = 0;
  longint chord [NPTS];
  longint diagq [NPTS];
  longint upq   [NPTS];
  longint slope [2][NPTS];

  seg_s   segs_due [$];
  seg_s   typed_segs [$];
  bit     typed_on = 0;
  int     errors = 0;
  bit     hold_req = 0;

  string  fname [8] = '{"start_x", "start_y", "slope_x", "slope_y",
                        "quad_x", "quad_y", "cubic_x", "cubic_y"};

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic longint clamp48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    logic [127:0] p;
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb}) >> 24;
    if (p > MAG47) p = MAG47;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Quotient in Q24.24, truncated toward zero; a zero divisor yields zero.
  function automatic longint fxdiv(longint a, longint b);
    logic [127:0] p;
    longint unsigned ma, mb;
    if (b == 0) return 0;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} << 24) / {64'd0, mb};
    if (p > MAG47) p = MAG47;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint isqrt(logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int b = 41; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic longint crd(int i, int ax);
    return (ax == 0 ? px[i] : py[i]) * 65536;
  endfunction

  function automatic longint lowc(int i, int n);
    return (i == n - 1) ? QONE : chord[i];
  endfunction

  // Natural-end tridiagonal solve for one axis: forward sweep, then back substitution.
  function automatic void solve_slopes(int ax, int n);
    longint r, h0, h1;
    slope[ax][0] = fxdiv(3 * (crd(1, ax) - crd(0, ax)), 2 * chord[0]);
    for (int i = 1; i < n; i++) begin
      if (i == n - 1) begin
        r = fxdiv(3 * (crd(i, ax) - crd(i - 1, ax)), chord[i - 1]);
      end else begin
        h0 = chord[i - 1];
        h1 = chord[i];
        r = clamp48(fxmul(fxdiv(h0, h1), crd(i + 1, ax) - crd(i, ax)) +
                    fxmul(fxdiv(h1, h0), crd(i, ax) - crd(i - 1, ax)));
        r = clamp48(3 * r);
      end
      slope[ax][i] = fxdiv(clamp48(r - fxmul(lowc(i, n), slope[ax][i - 1])), diagq[i]);
    end
    for (int i = n - 2; i >= 0; i--)
      slope[ax][i] = clamp48(slope[ax][i] - fxmul(upq[i], slope[ax][i + 1]));
  endfunction

  function automatic void spline_segments();
    longint dx, dy, h, d, bp, wa, wb, quad, cub;
    seg_s e;
    int n;
    n = np;
    if (n < 2) return;
    for (int i = 0; i + 1 < n; i++) begin
      dx = px[i + 1] - px[i];
      dy = py[i + 1] - py[i];
      chord[i] = isqrt(128'(dx * dx + dy * dy) << 32);
    end
    diagq[0] = QONE;
    upq[0] = QONE / 2;
    for (int i = 1; i < n; i++) begin
      if (i == n - 1) begin
        d = 2 * QONE;
        h = 0;
      end else begin
        d = clamp48(2 * (chord[i - 1] + chord[i]));
        h = chord[i - 1];
      end
      bp = clamp48(d - fxmul(lowc(i, n), upq[i - 1]));
      diagq[i] = bp;
      upq[i] = fxdiv(h, bp);
    end
    solve_slopes(0, n);
    solve_slopes(1, n);
    for (int k = 0; k + 1 < n; k++) begin
      e.d = '0;
      h = chord[k];
      for (int ax = 0; ax < 2; ax++) begin
        d = crd(k + 1, ax) - crd(k, ax);
        wa = slope[ax][k];
        wb = slope[ax][k + 1];
        quad = clamp48(fxdiv(fxdiv(3 * d, h), h) - fxdiv(clamp48(wb + 2 * wa), h));
        cub = clamp48(fxdiv(fxdiv(fxdiv(-2 * d, h), h), h) +
                      fxdiv(fxdiv(clamp48(wb + wa), h), h));
        e.d[48 * ax +: 48]       = crd(k, ax);
        e.d[96 + 48 * ax +: 48]  = wa;
        e.d[192 + 48 * ax +: 48] = quad;
        e.d[288 + 48 * ax +: 48] = cub;
      end
      e.d[430:384] = h[46:0];
      e.d[431] = pp[k];
      e.d[432] = pp[k + 1];
      e.l = (k + 2 == n);
      segs_due.push_back(e);
    end
  endfunction

  // Predictor update on every accepted input word.
  always @(posedge clk_i) begin
    longint x, y;
    int pre;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      x = {{40{s_axis_tdata[23]}}, s_axis_tdata[23:0]};
      y = {{40{s_axis_tdata[47]}}, s_axis_tdata[47:24]};
      case (s_axis_tuser)
        clcsf_pkg::OP_ADD: begin
          if (np < NPTS && !(np > 0 && px[np - 1] == x && py[np - 1] == y)) begin
            px[np] = x;
            py[np] = y;
            pp[np] = s_axis_tdata[48];
            np++;
          end
        end
        clcsf_pkg::OP_DEL: if (np >= 2) np--;
        clcsf_pkg::OP_FIN: begin
          pre = segs_due.size();
          spline_segments();
          if (typed_on) begin
            while (segs_due.size() > pre) void'(segs_due.pop_back());
            while (typed_segs.size() > 0) segs_due.push_back(typed_segs.pop_front());
            typed_on = 0;
          end
        end
        default: ;
      endcase
    end
  end

  // Segment checker.
  always @(posedge clk_i) begin
    seg_s e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (segs_due.size() == 0) begin
        report($sformatf("segment with none expected, data %h", m_axis_tdata));
      end else begin
        e = segs_due.pop_front();
        for (int f = 0; f < 8; f++)
          if (m_axis_tdata[48 * f +: 48] !== e.d[48 * f +: 48])
            report($sformatf("%s got %h want %h", fname[f],
                             m_axis_tdata[48 * f +: 48], e.d[48 * f +: 48]));
        if (m_axis_tdata[430:384] !== e.d[430:384])
          report($sformatf("seg_length got %h want %h", m_axis_tdata[430:384],
                           e.d[430:384]));
        if (m_axis_tdata[431] !== e.d[431]) report("pressure_start differs");
        if (m_axis_tdata[432] !== e.d[432]) report("pressure_end differs");
        if (m_axis_tlast !== e.l) report("last differs");
      end
    end
  end

  // Receiver: a stall pattern that steps through phases by tick count, plus one long hold-off.
  int ticks = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    ticks++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && m_axis_tvalid) begin
      hold_req <= 1'b0;
      hold_cnt = 8000;
      m_axis_tready <= 1'b0;
    end else begin
      case ((ticks >> 8) % 4)
        0, 3: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  int idle = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
    else idle++;
    if (idle >= IDLE_MAX) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Sender side.
  int burst_left = 8;

  task automatic send_word(input logic [1:0] op, input longint x, input longint y,
                           input bit pen);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pen, y[23:0], x[23:0]};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic drain_segments();
    while (segs_due.size() > 0) @(posedge clk_i);
  endtask

  // Mirror of the stroke on the stimulus side, so repeats and deletes are known.
  longint gx [NPTS];
  longint gy [NPTS];
  int     gn = 0;
  int     sent = 0;

  function automatic longint sx24(longint v);
    return {{40{v[23]}}, v[23:0]};
  endfunction

  task automatic add_point(input longint x, input longint y, input bit pen);
    if (gn < NPTS && !(gn > 0 && gx[gn - 1] == x && gy[gn - 1] == y)) begin
      gx[gn] = x;
      gy[gn] = y;
      gn++;
      sent++;
    end
    send_word(clcsf_pkg::OP_ADD, x, y, pen);
  endtask

  task automatic del_point();
    if (gn >= 2) begin
      gn--;
      sent++;
    end
    send_word(clcsf_pkg::OP_DEL, 0, 0, 0);
  endtask

  task automatic walk_point(input bit wide);
    longint x, y;
    if (gn == 0 || wide || $urandom_range(0, 7) == 0) begin
      x = sx24($urandom);
      y = sx24($urandom);
    end else begin
      x = sx24(gx[gn - 1] + $urandom_range(0, 4096) - 2048);
      y = sx24(gy[gn - 1] + $urandom_range(0, 4096) - 2048);
    end
    add_point(x, y, $urandom_range(0, 1));
  endtask

  row_s plan [20] = '{
    '{clcsf_pkg::OP_FIN, 0, 0, 0, 0},                    // finish on an empty stroke
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1},                   // delete with no points
    '{clcsf_pkg::OP_ADD, 0, 0, 1, -1},
    '{clcsf_pkg::OP_FIN, 0, 0, 0, 0},                    // finish with a single point
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1},                   // sole point is kept
    '{clcsf_pkg::OP_ADD, 0, 0, 0, -1},                   // repeated point, dropped
    '{clcsf_pkg::OP_ADD, 256, 0, 0, -1},
    '{clcsf_pkg::OP_FIN, 0, 0, 0, 1},                    // unit straight line
    '{OP_SPARE, 0, 0, 0, 0},                             // unused code, ignored
    '{clcsf_pkg::OP_ADD, 8388607, -8388608, 1, -1},
    '{clcsf_pkg::OP_ADD, -8388608, 8388607, 0, -1},
    '{clcsf_pkg::OP_ADD, 8388607, 8388607, 1, -1},
    '{clcsf_pkg::OP_FIN, 0, 0, 0, -1},
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1},
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1},
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1},
    '{clcsf_pkg::OP_ADD, -256, -512, 1, -1},
    '{clcsf_pkg::OP_ADD, -8388608, -8388608, 0, -1},
    '{clcsf_pkg::OP_FIN, 0, 0, 0, -1},
    '{clcsf_pkg::OP_DEL, 0, 0, 0, -1}
  };

  initial begin
    seg_s e;
    int m, strokes, cut;
    bit big_done;
    big_done = 0;
    strokes = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].typed >= 0 && plan[r].op == clcsf_pkg::OP_FIN) begin
        if (plan[r].typed == 1) begin
          // Two points one unit apart along x: a straight line with unit slope.
          e.d = '0;
          e.d[143:96] = QONE;
          e.d[430:384] = QONE;
          e.d[431] = 1'b1;
          e.l = 1'b1;
          typed_segs.push_back(e);
        end
        typed_on = 1;
      end
      send_word(plan[r].op, plan[r].x, plan[r].y, plan[r].pen);
      sent++;
    end

    // Hold off until every segment is back, then take over the stroke as it stands.
    s_axis_tvalid <= 1'b0;
    drain_segments();
    gn = np;
    for (int i = 0; i < np; i++) begin
      gx[i] = px[i];
      gy[i] = py[i];
    end

    while (sent < 380) begin
      strokes++;
      if (!big_done && sent > 180) begin
        // Overfill the buffer: the adds past the last slot are dropped.
        big_done = 1;
        for (int j = 0; j < 70; j++) walk_point(0);
      end else begin
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 6);
        for (int j = 0; j < m; j++) begin
          case ($urandom_range(0, 15))
            0: send_word(OP_SPARE, sx24($urandom), sx24($urandom), $urandom_range(0, 1));
            1: if (gn > 0) add_point(gx[gn - 1], gy[gn - 1], $urandom_range(0, 1));
            2: del_point();
            3: walk_point(1);
            default: walk_point(0);
          endcase
        end
      end
      if (strokes == 4) hold_req <= 1'b1;
      if ($urandom_range(0, 9) != 0 || gn > 12) begin
        send_word(clcsf_pkg::OP_FIN, 0, 0, 0);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        drain_segments();
      end
      cut = (gn > 10 || $urandom_range(0, 1)) ? gn - 1 : $urandom_range(0, gn > 0 ? gn - 1 : 0);
      for (int j = 0; j < cut; j++) del_point();
    end

    s_axis_tvalid <= 1'b0;
    drain_segments();
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
